// File: rtl/acp_pkg.sv
// ----------------------------------------------------------------------------
// acp_pkg
// Shared constants, register codes and control types of the allpass cascade.
// ----------------------------------------------------------------------------
package acp_pkg;

    localparam int STAGES_DEF      = 4;
    localparam int MAX_DELAY_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int GAIN_BITS_DEF   = 16;

    // Hardware never runs more than four stages: only four delay registers exist.
    localparam int MAX_HW_STAGES = 4;
    localparam int STG_W         = 2;
    localparam int DLY_REG_W     = 12;
    localparam int CNT_REG_W     = 3;
    localparam int REG_IDX_W     = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FIRST_DELAY   = 3'd0,
        REG_SECOND_DELAY  = 3'd1,
        REG_THIRD_DELAY   = 3'd2,
        REG_FOURTH_DELAY  = 3'd3,
        REG_SHARED_GAIN   = 3'd4,
        REG_PARALLEL_MODE = 3'd5,
        REG_STAGES_IN_USE = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic start;     // load block input, clear or seed accumulator
        logic ld_d;      // capture delay tap and form g*d
        logic ld_w;      // form saturated w
        logic mul_w;     // form g*w
        logic ld_y;      // form stage output and fold into accumulator
        logic parallel;  // stage input is block input, outputs are summed
    } t_alu_ctl;

endpackage

// File: rtl/acp_ram.sv
// ----------------------------------------------------------------------------
// acp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module acp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/acp_alu.sv
// ----------------------------------------------------------------------------
// acp_alu
// Shared allpass datapath: one multiplier, saturating adders and the stage
// accumulator, stepped by the sequencer one operation per cycle.
// ----------------------------------------------------------------------------
module acp_alu #(
    parameter int SAMPLE_BITS = 24,
    parameter int GAIN_BITS   = 16
) (
    input  logic                          i_clk,
    input  acp_pkg::t_alu_ctl             i_ctl,
    input  logic signed [GAIN_BITS-1:0]   i_gain,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_rdata,
    output logic signed [SAMPLE_BITS-1:0] o_w,
    output logic signed [SAMPLE_BITS-1:0] o_result
);
    import acp_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int PROD_W = SAMPLE_BITS + GAIN_BITS;
    localparam int EXT_W  = PROD_W + 2;
    localparam int ACC_W  = SAMPLE_BITS + 3;

    localparam logic signed [EXT_W-1:0] SMAX = {{(EXT_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SMIN = {{(EXT_W-SB+1){1'b1}}, {(SB-1){1'b0}}};

    function automatic logic signed [SB-1:0] sat(input logic signed [EXT_W-1:0] v);
        if (v > SMAX) begin
            return SMAX[SB-1:0];
        end else if (v < SMIN) begin
            return SMIN[SB-1:0];
        end
        return v[SB-1:0];
    endfunction

    logic signed [SB-1:0]     r_x;
    logic signed [SB-1:0]     r_d;
    logic signed [SB-1:0]     r_w;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [SB-1:0]     mul_opnd;
    logic signed [SB-1:0]     stage_in;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [EXT_W-1:0]  prod_ext;
    logic signed [EXT_W-1:0]  w_sum;
    logic signed [EXT_W-1:0]  y_sum;
    logic signed [SB-1:0]     y_sat;
    logic signed [ACC_W-1:0]  acc_sum;

    always_comb begin
        mul_opnd = i_ctl.ld_d ? i_rdata : r_w;
        stage_in = i_ctl.parallel ? r_x : r_acc[SB-1:0];
        prod_sh  = r_prod >>> (GAIN_BITS - 1);
        prod_ext = {{2{prod_sh[PROD_W-1]}}, prod_sh};
        w_sum    = {{(EXT_W-SB){stage_in[SB-1]}}, stage_in} + prod_ext;
        y_sum    = {{(EXT_W-SB){r_d[SB-1]}}, r_d} - prod_ext;
        y_sat    = sat(y_sum);
        acc_sum  = r_acc + {{(ACC_W-SB){y_sat[SB-1]}}, y_sat};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x   <= i_sample;
            r_acc <= i_ctl.parallel ? '0 : {{(ACC_W-SB){i_sample[SB-1]}}, i_sample};
        end else if (i_ctl.ld_y) begin
            r_acc <= i_ctl.parallel ? acc_sum : {{(ACC_W-SB){y_sat[SB-1]}}, y_sat};
        end
        if (i_ctl.ld_d) begin
            r_d <= i_rdata;
        end
        if (i_ctl.ld_d || i_ctl.mul_w) begin
            r_prod <= i_gain * mul_opnd;
        end
        if (i_ctl.ld_w) begin
            r_w <= sat(w_sum);
        end
    end

    assign o_w      = r_w;
    assign o_result = sat({{(EXT_W-ACC_W){r_acc[ACC_W-1]}}, r_acc});

endmodule

// File: rtl/allpass_cascade_filter_top.sv
// ----------------------------------------------------------------------------
// allpass_cascade_filter_top
// Cascade of up to four Schroeder allpass stages sharing one delay memory.
// ----------------------------------------------------------------------------
// Each accepted sample runs through the active stages one after another on a
// single multiplier; every stage steps through tap read, g*d, w, write with
// g*w, and output, and no new sample is taken until the last one has left
// the sequencer. The delay lines of all stages share one memory of
// STAGES*MAX_DELAY samples (at most four stages); after reset a clearing
// pass zeroes it one entry per cycle, during which o_ready stays low while
// configuration writes are still taken. A finished sample waits in the output
// register while the next one is taken.
module allpass_cascade_filter_top
    import acp_pkg::*;
#(
    parameter int STAGES      = acp_pkg::STAGES_DEF,
    parameter int MAX_DELAY   = acp_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = acp_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_BITS   = acp_pkg::GAIN_BITS_DEF,
    parameter int CFG_W       = (GAIN_BITS > acp_pkg::DLY_REG_W) ? GAIN_BITS
                                                                 : acp_pkg::DLY_REG_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [acp_pkg::REG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]                  i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [SAMPLE_BITS-1:0]     i_in_sample,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_out_sample
);

    localparam int USE_LINES = (STAGES < MAX_HW_STAGES) ? STAGES : MAX_HW_STAGES;
    localparam int DEPTH     = USE_LINES * MAX_DELAY;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int POS_W     = $clog2(MAX_DELAY);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_MULD, S_WCALC, S_WRITE, S_YCALC, S_DONE
    } t_state;

    t_state r_state;

    logic [DLY_REG_W-1:0]        r_delay [MAX_HW_STAGES];
    logic signed [GAIN_BITS-1:0] r_gain;
    logic                        r_parallel;
    logic [CNT_REG_W-1:0]        r_stages;

    logic [POS_W-1:0]            r_wpos;
    logic [STG_W-1:0]            r_stage;
    logic [STG_W-1:0]            r_last;
    logic [ADDR_W-1:0]           r_clr_addr;
    logic                        r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    t_alu_ctl                    alu_ctl;
    logic signed [SAMPLE_BITS-1:0] alu_w;
    logic signed [SAMPLE_BITS-1:0] alu_result;
    logic [SAMPLE_BITS-1:0]      ram_rdata;
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [SAMPLE_BITS-1:0]      ram_wdata;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [POS_W-1:0]            rd_pos;
    logic [STG_W-1:0]            last_stage;
    logic                        in_beat;
    logic                        out_free;

    // Effective stage count and read tap, with delay clamped to 1..MAX_DELAY-1.
    always_comb begin
        int n_eff;
        int dl;
        int rp;
        n_eff = (r_stages == '0) ? 1 : int'(r_stages);
        if (n_eff > USE_LINES) begin
            n_eff = USE_LINES;
        end
        last_stage = STG_W'(n_eff - 1);

        dl = int'(r_delay[r_stage]);
        if (dl < 1) begin
            dl = 1;
        end
        if (dl > MAX_DELAY - 1) begin
            dl = MAX_DELAY - 1;
        end
        rp = int'(r_wpos) - dl;
        if (rp < 0) begin
            rp = rp + MAX_DELAY;
        end
        rd_pos    = POS_W'(rp);
        ram_raddr = ADDR_W'(int'(r_stage) * MAX_DELAY + int'(rd_pos));
    end

    assign in_beat  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);

    always_comb begin
        alu_ctl          = '0;
        alu_ctl.parallel = r_parallel;
        alu_ctl.start    = in_beat;
        alu_ctl.ld_d     = (r_state == S_MULD);
        alu_ctl.ld_w     = (r_state == S_WCALC);
        alu_ctl.mul_w    = (r_state == S_WRITE);
        alu_ctl.ld_y     = (r_state == S_YCALC);
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == S_WRITE);
            ram_waddr = ADDR_W'(int'(r_stage) * MAX_DELAY + int'(r_wpos));
            ram_wdata = alu_w;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_HW_STAGES; i++) begin
                r_delay[i] <= DLY_REG_W'(1);
            end
            r_gain     <= '0;
            r_parallel <= 1'b0;
            r_stages   <= CNT_REG_W'(4);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_FIRST_DELAY, REG_SECOND_DELAY, REG_THIRD_DELAY, REG_FOURTH_DELAY: begin
                    r_delay[i_cfg_idx[STG_W-1:0]] <= i_cfg_data[DLY_REG_W-1:0];
                end
                REG_SHARED_GAIN: begin
                    r_gain <= i_cfg_data[GAIN_BITS-1:0];
                end
                REG_PARALLEL_MODE: begin
                    r_parallel <= i_cfg_data[0];
                end
                REG_STAGES_IN_USE: begin
                    r_stages <= i_cfg_data[CNT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_wpos      <= '0;
            r_stage     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new result beat, or drop the one just taken
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_beat) begin
                        r_stage <= '0;
                        r_last  <= last_stage;
                        r_state <= S_READ;
                    end
                end
                S_READ:  r_state <= S_MULD;
                S_MULD:  r_state <= S_WCALC;
                S_WCALC: r_state <= S_WRITE;
                S_WRITE: r_state <= S_YCALC;
                S_YCALC: begin
                    if (r_stage == r_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_stage <= r_stage + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    // hold the result until the output register drains
                    if (out_free) begin
                        r_out       <= alu_result;
                        r_wpos      <= (r_wpos == POS_W'(MAX_DELAY - 1)) ? '0
                                                                         : r_wpos + 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    acp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    acp_alu #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .GAIN_BITS   (GAIN_BITS)
    ) u_alu (
        .i_clk    (i_clk),
        .i_ctl    (alu_ctl),
        .i_gain   (r_gain),
        .i_sample (i_in_sample),
        .i_rdata  (ram_rdata),
        .o_w      (alu_w),
        .o_result (alu_result)
    );

    assign o_valid      = r_out_valid;
    assign o_out_sample = r_out;

endmodule

// File: rtl/acp_checker.sv
// ----------------------------------------------------------------------------
// acp_checker
// Port-level checks of the allpass cascade, bound to the top level.
// ----------------------------------------------------------------------------
module acp_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [SAMPLE_BITS-1:0] o_out_sample
);

    // Reset empties the output and starts the memory clear.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("output or input open right after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_sample))
        else $error("result beat dropped or changed while stalled");

    // One sample at a time: the input closes after a beat.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second input beat taken while busy");

    // No result can come out of the sequencer too soon after an input beat.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |-> ##2 !$rose(o_valid))
        else $error("result appeared too early");

endmodule

bind allpass_cascade_filter_top acp_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_acp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_out_sample (o_out_sample)
);
